[rtl/sphrm_pkg.sv]
// ----------------------------------------------------------------------------
// sphrm_pkg
// Shared types and constants of the stereo peak-hold and RMS level meter.
// ----------------------------------------------------------------------------
package sphrm_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int LANES       = 2;
	localparam int MAG_BITS    = SAMPLE_BITS - 1;
	localparam int CNT_BITS    = 24;
	localparam int FAC_BITS    = 24;
	localparam int SUM_BITS    = 64;
	localparam int SCL_BITS    = 32;
	localparam int LANE_BITS   = 1;

	localparam logic [MAG_BITS-1:0] MAG_MAX = {MAG_BITS{1'b1}};
	localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

	localparam logic [1:0] REG_PEAK_DECAY = 2'd0;
	localparam logic [1:0] REG_MEM_DECAY  = 2'd1;
	localparam logic [1:0] REG_HOLD_LEN   = 2'd2;
	localparam logic [1:0] REG_RMS_SCALE  = 2'd3;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_sample;
		logic signed [SAMPLE_BITS-1:0] right_sample;
		logic                          block_end;
	} in_item_t;

	typedef struct packed {
		logic [MAG_BITS-1:0] left_peak;
		logic [MAG_BITS-1:0] right_peak;
		logic [MAG_BITS-1:0] left_memory_peak;
		logic [MAG_BITS-1:0] right_memory_peak;
		logic [MAG_BITS-1:0] left_rms;
		logic [MAG_BITS-1:0] right_rms;
	} out_item_t;

	typedef struct packed {
		logic                 sample;    // per-sample update of lane
		logic                 close;     // block-end update of lane
		logic                 scale_hi;  // square sum high part times scale
		logic                 scale_lo;  // low part times scale
		logic                 root_init;
		logic                 root_step;
		logic                 root_done; // store rms of lane
		logic                 count;     // block length update
		logic                 clear_len;
		logic [LANE_BITS-1:0] lane;
	} cmd_t;

	typedef struct packed {
		logic root_busy;
	} sts_t;

endpackage

[rtl/sphrm_if.sv]
// ----------------------------------------------------------------------------
// sphrm_if
// Valid/ready channel carrying one item.
// ----------------------------------------------------------------------------
interface sphrm_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/stereo_peak_hold_rms_meter_unit.sv]
// ----------------------------------------------------------------------------
// stereo_peak_hold_rms_meter_unit
// Stereo peak-hold and RMS level meter, one result per closed block.
//
//   channel  dir  payload
//   in_ch    in   left_sample, right_sample, block_end
//   out_ch   out  peaks, memory peaks, rms per lane
//   apb      in   four config registers at 4*i
//
// Ordinary sample: one update per lane, then ready again.
// Block end: per lane close, two scaling multiplies and a 32-step bit-pair
// root (with init and done) in one shared unit, then the result register.
// Result waits in out register; the block stalls at EMIT while it is full.
// Reset clears lane state except rms and sample registers, and loads register defaults.
// ----------------------------------------------------------------------------
module stereo_peak_hold_rms_meter_unit
	import sphrm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	sphrm_if.sink       in_ch,
	sphrm_if.source     out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cmd_t                cmd;
	sts_t                sts;
	logic                in_fire, out_load;
	logic [FAC_BITS-1:0] peak_decay, mem_decay;
	logic [CNT_BITS-1:0] hold_len;
	logic [SCL_BITS-1:0] rms_scale;
	out_item_t           result;
	in_item_t            in_item;
	logic                ovalid_q;
	out_item_t           odata_q;

	assign in_item = in_ch.data;
	assign in_fire = in_ch.valid && in_ch.ready;

	sphrm_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.peak_decay, .mem_decay, .hold_len, .rms_scale
	);

	sphrm_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .in_last(in_item.block_end), .in_ready(in_ch.ready),
		.out_busy(ovalid_q && !out_ch.ready), .out_load, .sts, .cmd
	);

	sphrm_dp u_dp (
		.clk, .arst_n, .cmd, .sts, .in_item, .in_fire,
		.peak_decay, .mem_decay, .hold_len, .rms_scale, .result
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovalid_q <= 1'b0;
		else if (out_load)
			ovalid_q <= 1'b1;
		else if (out_ch.ready)
			ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			odata_q <= result;
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.data = odata_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !(ovalid_q && !out_ch.ready)) else $error("result overwritten");
	a_root_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.sample, cmd.close, cmd.scale_hi, cmd.scale_lo, cmd.root_init,
			cmd.root_step, cmd.root_done}) <= 1) else $error("datapath command clash");
	a_busy_in: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sample |-> !in_ch.ready) else $error("input taken while updating");

endmodule

[rtl/sphrm_ctrl.sv]
// ----------------------------------------------------------------------------
// sphrm_ctrl
// Sequencer: per-sample lane updates, and at block end the close, scaling
// and iterative root for each lane.
// ----------------------------------------------------------------------------
module sphrm_ctrl
	import sphrm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic in_last,
	output logic in_ready,
	input  logic out_busy,
	output logic out_load,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SAMP  = 3'd1;
	localparam logic [2:0] ST_CLOSE = 3'd2;
	localparam logic [2:0] ST_SHI   = 3'd3;
	localparam logic [2:0] ST_SLO   = 3'd4;
	localparam logic [2:0] ST_ROOT  = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	logic [2:0]           state_q;
	logic [LANE_BITS-1:0] lane_q;
	logic                 last_q;
	logic                 init_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.lane = lane_q;
		out_load = 1'b0;
		case (state_q)
			ST_SAMP:  cmd.sample = 1'b1;
			ST_CLOSE: cmd.close = 1'b1;
			ST_SHI:   cmd.scale_hi = 1'b1;
			ST_SLO:   cmd.scale_lo = 1'b1;
			ST_ROOT: begin
				cmd.root_init = init_q;
				cmd.root_step = !init_q && sts.root_busy;
				cmd.root_done = !init_q && !sts.root_busy;
			end
			ST_EMIT:  begin
				out_load = !out_busy;
				cmd.clear_len = !out_busy;
			end
			default: ;
		endcase
		cmd.count = in_fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lane_q <= '0;
			last_q <= 1'b0;
			init_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (in_fire) begin
					state_q <= ST_SAMP;
					lane_q <= '0;
					last_q <= in_last;
				end
				ST_SAMP: begin
					if (lane_q == LANE_BITS'(LANES - 1)) begin
						lane_q <= '0;
						state_q <= last_q ? ST_CLOSE : ST_IDLE;
					end else begin
						lane_q <= lane_q + 1'b1;
					end
				end
				ST_CLOSE: state_q <= ST_SHI;
				ST_SHI:   state_q <= ST_SLO;
				ST_SLO: begin
					state_q <= ST_ROOT;
					init_q <= 1'b1;
				end
				ST_ROOT: begin
					init_q <= 1'b0;
					if (!init_q && !sts.root_busy) begin
						if (lane_q == LANE_BITS'(LANES - 1)) begin
							state_q <= ST_EMIT;
						end else begin
							lane_q <= lane_q + 1'b1;
							state_q <= ST_CLOSE;
						end
					end
				end
				ST_EMIT: if (!out_busy) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/sphrm_dp.sv]
// ----------------------------------------------------------------------------
// sphrm_dp
// Lane state, decay multipliers, block close, scaling and bit-pair root.
// ----------------------------------------------------------------------------
module sphrm_dp
	import sphrm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  in_item_t            in_item,
	input  logic                in_fire,
	input  logic [FAC_BITS-1:0] peak_decay,
	input  logic [FAC_BITS-1:0] mem_decay,
	input  logic [CNT_BITS-1:0] hold_len,
	input  logic [SCL_BITS-1:0] rms_scale,
	output out_item_t           result
);

	logic [MAG_BITS-1:0] peak_q [LANES];
	logic [MAG_BITS-1:0] mem_q  [LANES];
	logic [MAG_BITS-1:0] run_q  [LANES];
	logic [SUM_BITS-1:0] sum_q  [LANES];
	logic [MAG_BITS-1:0] bmax_q [LANES];
	logic [CNT_BITS-1:0] hold_q [LANES];
	logic [MAG_BITS-1:0] rms_q  [LANES];
	logic [CNT_BITS-1:0] blen_q;
	logic signed [SAMPLE_BITS-1:0] samp_q [LANES];

	logic [SUM_BITS-1:0] m_q;      // scaled sum (root operand)
	logic [SUM_BITS-1:0] hi_q;
	logic [SUM_BITS-1:0] res_q;
	logic [SUM_BITS-1:0] bit_q;

	// sample path
	logic signed [SAMPLE_BITS-1:0] s;
	logic [SAMPLE_BITS-1:0]        mag;
	logic [MAG_BITS-1:0]           pk;
	logic [2*SAMPLE_BITS-1:0]      sq;
	logic [MAG_BITS+FAC_BITS-1:0]  pdec, rdec;
	logic [SUM_BITS-FAC_BITS-1:0]  shi;
	logic [FAC_BITS-1:0]           slo;
	logic [SUM_BITS+FAC_BITS-1:0]  nsw;
	logic [SUM_BITS-1:0]           ns;
	logic [SUM_BITS:0]             nsum;

	always_comb begin
		s = samp_q[cmd.lane];
		mag = s[SAMPLE_BITS-1] ? SAMPLE_BITS'(-s) : SAMPLE_BITS'(s);
		pk = mag[SAMPLE_BITS-1] ? MAG_MAX : mag[MAG_BITS-1:0];
		sq = mag * mag;
		pdec = peak_q[cmd.lane] * peak_decay;
		rdec = run_q[cmd.lane] * mem_decay;
		shi = sum_q[cmd.lane][SUM_BITS-1:FAC_BITS];
		slo = sum_q[cmd.lane][FAC_BITS-1:0];
		nsw = shi * peak_decay + ((slo * peak_decay) >> FAC_BITS);
		ns = nsw[SUM_BITS-1:0];
		nsum = {1'b0, ns} + {{(SUM_BITS+1-2*SAMPLE_BITS){1'b0}}, sq};
	end

	// close path
	logic [MAG_BITS-1:0] npk, cand, nmem;
	logic [CNT_BITS:0]   hsum;
	logic [CNT_BITS-1:0] nhold;
	always_comb begin
		npk = (bmax_q[cmd.lane] > peak_q[cmd.lane]) ? bmax_q[cmd.lane] : peak_q[cmd.lane];
		hsum = {1'b0, hold_q[cmd.lane]} + {1'b0, blen_q};
		nhold = hsum[CNT_BITS] ? CNT_MAX : hsum[CNT_BITS-1:0];
		if (!(npk < run_q[cmd.lane]))
			nhold = '0;
		cand = (nhold < hold_len) ? mem_q[cmd.lane] : run_q[cmd.lane];
		nmem = (npk > cand) ? npk : cand;
	end

	// scaling: hi*k + ((lo*k)>>32)
	logic [SUM_BITS-1:0] prod_hi;
	logic [SUM_BITS-1:0] prod_lo;
	assign prod_hi = sum_q[cmd.lane][SUM_BITS-1:SCL_BITS] * rms_scale;
	assign prod_lo = sum_q[cmd.lane][SCL_BITS-1:0] * rms_scale;

	// root step
	logic [SUM_BITS-1:0] rb;
	logic                ge;
	assign rb = res_q + bit_q;
	assign ge = (m_q >= rb);
	assign sts.root_busy = (bit_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++) begin
				peak_q[i] <= '0;
				mem_q[i] <= '0;
				run_q[i] <= '0;
				sum_q[i] <= '0;
				bmax_q[i] <= '0;
				hold_q[i] <= '0;
			end
			blen_q <= '0;
		end else begin
			if (cmd.sample) begin
				if (pk > bmax_q[cmd.lane]) bmax_q[cmd.lane] <= pk;
				peak_q[cmd.lane] <= pdec[MAG_BITS+FAC_BITS-1:FAC_BITS];
				run_q[cmd.lane] <= rdec[MAG_BITS+FAC_BITS-1:FAC_BITS];
				sum_q[cmd.lane] <= nsum[SUM_BITS] ? {SUM_BITS{1'b1}} : nsum[SUM_BITS-1:0];
			end
			if (cmd.close) begin
				peak_q[cmd.lane] <= npk;
				hold_q[cmd.lane] <= nhold;
				mem_q[cmd.lane] <= nmem;
				run_q[cmd.lane] <= nmem;
				bmax_q[cmd.lane] <= '0;
			end
			if (cmd.count && blen_q != CNT_MAX)
				blen_q <= blen_q + 1'b1;
			else if (cmd.clear_len)
				blen_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			samp_q[0] <= in_item.left_sample;
			samp_q[LANES-1] <= in_item.right_sample;
		end
		if (cmd.scale_hi)
			hi_q <= prod_hi;
		if (cmd.scale_lo)
			m_q <= hi_q + (prod_lo >> SCL_BITS);
		if (cmd.root_init) begin
			res_q <= '0;
			bit_q <= {2'b01, {(SUM_BITS-2){1'b0}}};
		end else if (cmd.root_step) begin
			if (ge) begin
				m_q <= m_q - rb;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.root_done)
			rms_q[cmd.lane] <= (res_q > SUM_BITS'(MAG_MAX)) ? MAG_MAX : res_q[MAG_BITS-1:0];
	end

	assign result.left_peak = peak_q[0];
	assign result.right_peak = peak_q[LANES-1];
	assign result.left_memory_peak = mem_q[0];
	assign result.right_memory_peak = mem_q[LANES-1];
	assign result.left_rms = rms_q[0];
	assign result.right_rms = rms_q[LANES-1];

endmodule

[rtl/sphrm_regs.sv]
// ----------------------------------------------------------------------------
// sphrm_regs
// APB register file for decay factors, hold length and RMS scale.
// ----------------------------------------------------------------------------
module sphrm_regs
	import sphrm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output logic [FAC_BITS-1:0] peak_decay,
	output logic [FAC_BITS-1:0] mem_decay,
	output logic [CNT_BITS-1:0] hold_len,
	output logic [SCL_BITS-1:0] rms_scale
);

	logic [1:0] idx;
	assign idx = paddr[3:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_decay <= 24'd16775144;
			mem_decay <= 24'd16776377;
			hold_len <= 24'd50000;
			rms_scale <= 32'd530505;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			case (idx)
				REG_PEAK_DECAY: peak_decay <= pwdata[FAC_BITS-1:0];
				REG_MEM_DECAY:  mem_decay <= pwdata[FAC_BITS-1:0];
				REG_HOLD_LEN:   hold_len <= pwdata[CNT_BITS-1:0];
				REG_RMS_SCALE:  rms_scale <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PEAK_DECAY: prdata = {8'd0, peak_decay};
			REG_MEM_DECAY:  prdata = {8'd0, mem_decay};
			REG_HOLD_LEN:   prdata = {8'd0, hold_len};
			REG_RMS_SCALE:  prdata = rms_scale;
			default:        prdata = '0;
		endcase
	end

endmodule

[tb/tb_stereo_peak_hold_rms_meter_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stereo_peak_hold_rms_meter_unit
// Checks the level meter's peak, held peak and rms results per closed block.
// A local model of the lane state predicts each result; directed extremes,
// then random samples with idle bursts; settings change between phases.
// ----------------------------------------------------------------------------
module tb_stereo_peak_hold_rms_meter_unit
	import sphrm_pkg::*;
;

	class meter_scoreboard;
		logic [FAC_BITS-1:0] pk_fac, mem_fac;
		logic [CNT_BITS-1:0] hold_len;
		logic [SCL_BITS-1:0] scale;
		logic [MAG_BITS-1:0] peak [LANES];
		logic [MAG_BITS-1:0] mem [LANES];
		logic [MAG_BITS-1:0] mem_run [LANES];
		logic [MAG_BITS-1:0] blk_max [LANES];
		logic [SUM_BITS-1:0] sq_sum [LANES];
		logic [CNT_BITS-1:0] hold_cnt [LANES];
		logic [CNT_BITS-1:0] blk_len;
		out_item_t levels_q[$];
		int errors;

		function void reset_state();
			pk_fac = 24'd16775144; mem_fac = 24'd16776377;
			hold_len = 24'd50000; scale = 32'd530505;
			for (int i = 0; i < LANES; i++) begin
				peak[i] = '0; mem[i] = '0; mem_run[i] = '0; blk_max[i] = '0;
				sq_sum[i] = '0; hold_cnt[i] = '0;
			end
			blk_len = '0; levels_q.delete(); errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] v);
			case (idx)
				REG_PEAK_DECAY: pk_fac = v[FAC_BITS-1:0];
				REG_MEM_DECAY: mem_fac = v[FAC_BITS-1:0];
				REG_HOLD_LEN: hold_len = v[CNT_BITS-1:0];
				REG_RMS_SCALE: scale = v;
				default: ;
			endcase
		endfunction

		function logic [63:0] root(logic [63:0] v);
			logic [63:0] r, b;
			r = 0; b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b; r = (r >> 1) + b;
				end else r >>= 1;
				b >>= 2;
			end
			return r;
		endfunction

		function void note_sample(in_item_t it);
			logic [SAMPLE_BITS-1:0] raw;
			logic [SAMPLE_BITS:0] mag;
			logic [MAG_BITS-1:0] pk;
			logic [63:0] sq, ns, cand, rms, m;
			logic [24:0] hc;
			out_item_t o;
			for (int i = 0; i < LANES; i++) begin
				raw = (i == 0) ? it.left_sample : it.right_sample;
				mag = raw[SAMPLE_BITS-1] ? (25'd1 << SAMPLE_BITS) - raw : {1'b0, raw};
				pk = (mag > MAG_MAX) ? MAG_MAX : mag[MAG_BITS-1:0];
				if (pk > blk_max[i]) blk_max[i] = pk;
				peak[i] = MAG_BITS'((64'(peak[i]) * pk_fac) >> 24);
				mem_run[i] = MAG_BITS'((64'(mem_run[i]) * mem_fac) >> 24);
				sq = 64'(mag) * mag;
				ns = (sq_sum[i] >> 24) * pk_fac + (((sq_sum[i] & 64'hFFFFFF) * pk_fac) >> 24);
				sq_sum[i] = (ns > ~sq) ? '1 : ns + sq;
			end
			if (blk_len != CNT_MAX) blk_len++;
			if (!it.block_end) return;
			for (int i = 0; i < LANES; i++) begin
				if (blk_max[i] > peak[i]) peak[i] = blk_max[i];
				hc = hold_cnt[i] + blk_len;
				hold_cnt[i] = hc[24] ? CNT_MAX : hc[23:0];
				if (!(peak[i] < mem_run[i])) hold_cnt[i] = '0;
				cand = (hold_cnt[i] < hold_len) ? 64'(mem[i]) : 64'(mem_run[i]);
				mem[i] = (peak[i] > cand) ? peak[i] : cand[MAG_BITS-1:0];
				mem_run[i] = mem[i];
				blk_max[i] = '0;
				m = (sq_sum[i] >> 32) * scale + (((sq_sum[i] & 64'hFFFFFFFF) * scale) >> 32);
				rms = root(m);
				if (rms > MAG_MAX) rms = MAG_MAX;
				if (i == 0) begin
					o.left_peak = peak[i]; o.left_memory_peak = mem[i];
					o.left_rms = rms[MAG_BITS-1:0];
				end else begin
					o.right_peak = peak[i]; o.right_memory_peak = mem[i];
					o.right_rms = rms[MAG_BITS-1:0];
				end
			end
			blk_len = '0;
			levels_q.push_back(o);
		endfunction

		function void check_levels(out_item_t a);
			out_item_t e;
			if (levels_q.size() == 0) begin
				$error("unexpected result %h", a); errors++; return;
			end
			e = levels_q.pop_front();
			if (a.left_peak !== e.left_peak) begin
				$error("left_peak exp %0d got %0d", e.left_peak, a.left_peak); errors++;
			end
			if (a.right_peak !== e.right_peak) begin
				$error("right_peak exp %0d got %0d", e.right_peak, a.right_peak); errors++;
			end
			if (a.left_memory_peak !== e.left_memory_peak) begin
				$error("left_memory_peak exp %0d got %0d", e.left_memory_peak,
					a.left_memory_peak); errors++;
			end
			if (a.right_memory_peak !== e.right_memory_peak) begin
				$error("right_memory_peak exp %0d got %0d", e.right_memory_peak,
					a.right_memory_peak); errors++;
			end
			if (a.left_rms !== e.left_rms) begin
				$error("left_rms exp %0d got %0d", e.left_rms, a.left_rms); errors++;
			end
			if (a.right_rms !== e.right_rms) begin
				$error("right_rms exp %0d got %0d", e.right_rms, a.right_rms); errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	sphrm_if #(in_item_t) in_ch();
	sphrm_if #(out_item_t) out_ch();

	stereo_peak_hold_rms_meter_unit dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	meter_scoreboard sb;
	bit idle_on;
	bit hold_off;
	bit req_up;
	int idle_cnt;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0; penable <= 0; pwrite <= 0;
		sb.set_reg(idx, v);
	endtask

	// drop valid once, only if a request is still up
	task automatic release_input();
		if (req_up) begin
			in_ch.valid <= 0;
			req_up = 0;
		end
	endtask

	task automatic send_request(logic signed [23:0] l, logic signed [23:0] r, logic e);
		in_item_t it;
		int g;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			g = $urandom_range(1, 7);
			release_input();
			repeat (g) @(posedge clk);
		end
		it.left_sample = l; it.right_sample = r; it.block_end = e;
		in_ch.valid <= 1; in_ch.data <= it;
		req_up = 1;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_sample(it);
	endtask

	task automatic drain();
		release_input();
		while (sb.levels_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic [23:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2: return 24'd0;
			3: return 24'($signed($urandom_range(0, 2000)) - 1000);
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic random_blocks(int n, int maxlen);
		int len;
		while (n > 0) begin
			len = $urandom_range(1, maxlen);
			for (int k = 1; k <= len && n > 0; k++) begin
				send_request(rand_sample(), rand_sample(), k == len || n == 1);
				n--;
			end
		end
		release_input();
	endtask

	// result side
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) sb.check_levels(out_ch.data);
		if (hold_off) begin
			out_ch.ready <= 0;
		end else if (idle_on && idle_cnt == 0 && $urandom_range(0, 4) == 0) begin
			idle_cnt <= $urandom_range(1, 7); out_ch.ready <= 0;
		end else if (idle_cnt > 1) begin
			idle_cnt <= idle_cnt - 1; out_ch.ready <= 0;
		end else begin
			idle_cnt <= 0; out_ch.ready <= 1;
		end
	end

	// watchdog
	int quiet;
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_off)
			quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("FAIL stereo_peak_hold_rms_meter_unit");
			$finish;
		end
	end

	initial begin
		sb = new();
		sb.reset_state();
		quiet = 0; idle_cnt = 0; idle_on = 0; hold_off = 0; req_up = 0;
		arst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_ch.valid = 0; in_ch.data = '0; out_ch.ready = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes at reset defaults
		send_request(24'h7FFFFF, 24'h800000, 1);
		send_request(24'h800000, 24'h7FFFFF, 0);
		send_request(24'h000001, 24'hFFFFFF, 1);
		send_request(24'd0, 24'd0, 1);
		send_request(24'h555555, 24'hAAAAAA, 0);
		send_request(24'hAAAAAA, 24'h555555, 1);
		drain();
		write_reg(REG_PEAK_DECAY, 32'h00FFFFFF);
		write_reg(REG_MEM_DECAY, 32'h0);
		write_reg(REG_HOLD_LEN, 32'd0);
		write_reg(REG_RMS_SCALE, 32'hFFFFFFFF);
		for (int k = 0; k < 6; k++) send_request(24'h800000, 24'h800000, k[0]);
		send_request(24'd0, 24'd0, 1);
		drain();
		write_reg(REG_PEAK_DECAY, 32'h0);
		write_reg(REG_MEM_DECAY, 32'h00FFFFFF);
		write_reg(REG_HOLD_LEN, 32'h00FFFFFF);
		write_reg(REG_RMS_SCALE, 32'h0);
		send_request(24'h400000, 24'h7FFFFF, 1);
		send_request(24'h000100, 24'h000010, 1);
		send_request(24'h000000, 24'h000000, 1);
		drain();
		write_reg(REG_HOLD_LEN, 32'd3);
		write_reg(REG_RMS_SCALE, 32'h01000000);
		write_reg(REG_PEAK_DECAY, 32'h00F00000);
		write_reg(REG_MEM_DECAY, 32'h00FF0000);
		idle_on = 1;
		random_blocks(150, 6);
		// long output stall while input keeps going
		hold_off = 1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			random_blocks(20, 2);
		join
		drain();
		write_reg(REG_PEAK_DECAY, $urandom);
		write_reg(REG_MEM_DECAY, $urandom);
		write_reg(REG_HOLD_LEN, $urandom_range(0, 40));
		write_reg(REG_RMS_SCALE, $urandom);
		random_blocks(150, 10);
		drain();
		write_reg(REG_PEAK_DECAY, 32'd16775144);
		write_reg(REG_MEM_DECAY, 32'd16776377);
		write_reg(REG_HOLD_LEN, 32'd50000);
		write_reg(REG_RMS_SCALE, 32'd530505);
		idle_on = 0;
		random_blocks(110, 8);
		drain();
		if (sb.errors == 0 && sb.levels_q.size() == 0) begin
			$display("PASS stereo_peak_hold_rms_meter_unit");
		end else begin
			$display("FAIL stereo_peak_hold_rms_meter_unit");
		end
		$finish;
	end
endmodule
